// File: rtl/assert_macros.svh
// ------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent assertions on a clock with active-low reset
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is low
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// implication, post checked in the cycle after pre
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: rtl/fscc_pkg.sv
// ------------------------------------------------------------------------
// fscc_pkg
// class codes, character constants and byte tests for the classifier
// ------------------------------------------------------------------------
package fscc_pkg;

  typedef enum logic [2:0] {
    CLS_DEFAULT  = 3'd0,
    CLS_OPERATOR = 3'd1,
    CLS_IDENT    = 3'd2,
    CLS_COMMENT  = 3'd3,
    CLS_STRING   = 3'd4,
    CLS_LITERAL  = 3'd5,
    CLS_SPECIAL  = 3'd6,
    CLS_FIELD    = 3'd7
  } class_e;

  typedef enum logic [1:0] {
    LE_NONE = 2'd0,
    LE_CR   = 2'd1,
    LE_LF   = 2'd2
  } line_end_e;

  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_RBRK   = 8'h5d;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_COMMA) ||
           (c == CH_LBRK) || (c == CH_RBRK);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return (c == CH_DOLLAR) || (c == CH_PCT) || (c == CH_QUOTE);
  endfunction

  function automatic logic is_literal(input logic [7:0] c);
    return !is_operator(c) && !is_special(c) && (c != CH_CR) && (c != CH_LF);
  endfunction

endpackage

// File: rtl/format_script_char_classifier.sv
// path: an accepted item passes the input register, then the result register, to
//   reach the outputs; an output stall holds it where it is
// throughput: one item per cycle while the output does not stall; the class state
//   updates as an item moves from the input register to the result register
// reset: rst_ni clears both valid flags, the class state and start_style
// ------------------------------------------------------------------------
// format_script_char_classifier
// assigns a syntax class to each byte of a format-script text stream
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module format_script_char_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic [7:0] next_ch_i,
  input  logic       first_i,
  input  logic       last_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] style_o,
  output logic       end_mark_o,
  // start_style register
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i
);
  import fscc_pkg::*;

  // configuration
  class_e    start_style_q;

  // input register
  logic      in_vld_q;
  logic [7:0] ch_q;
  logic [7:0] nx_q;
  logic      first_q;
  logic      last_q;

  // classifier state
  class_e    cls_q, cls_d;
  logic      pair_q, pair_d;
  line_end_e prev_q, prev_d;

  // result register
  logic      out_vld_q;
  class_e    style_q, style_d;
  logic      end_q;

  logic      advance;
  logic      line_start;
  class_e    cls_cur;
  class_e    cls_mid;
  logic      closed;

  // the input stage moves on whenever the result slot is free or being taken
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;

  // ---- classification of the byte in the input register ----
  always_comb begin
    // segment start reloads the class and counts as a line start
    cls_cur    = first_q ? start_style_q : cls_q;
    line_start = first_q || (prev_q == LE_LF) || ((prev_q == LE_CR) && (ch_q != CH_LF));

    cls_mid = cls_cur;
    closed  = 1'b0;
    cls_d   = cls_cur;
    pair_d  = 1'b0;
    style_d = cls_cur;

    if (pair_q && !first_q) begin
      // second byte of a two-byte token: same class, no decision
      style_d = cls_cur;
      cls_d   = cls_cur;
    end else begin
      // does the class in force end at this byte
      unique case (cls_cur)
        CLS_OPERATOR, CLS_SPECIAL: cls_mid = CLS_DEFAULT;
        CLS_IDENT:   if (!is_word(ch_q)) cls_mid = CLS_DEFAULT;
        CLS_COMMENT: if (line_start) cls_mid = CLS_DEFAULT;
        CLS_STRING:  closed = (ch_q == CH_QUOTE);
        CLS_LITERAL: if (!is_literal(ch_q)) cls_mid = CLS_DEFAULT;
        CLS_FIELD:   closed = (ch_q == CH_PCT);
        default:     cls_mid = cls_cur;
      endcase

      if (closed) begin
        // closing quote or percent keeps the class, then back to default
        style_d = cls_cur;
        cls_d   = CLS_DEFAULT;
      end else begin
        cls_d = cls_mid;
        if (cls_mid == CLS_DEFAULT) begin
          // a new class may begin here, first match wins
          priority if (ch_q == CH_SLASH && nx_q == CH_SLASH) begin
            cls_d  = CLS_COMMENT;
            pair_d = 1'b1;
          end else if (is_operator(ch_q)) begin
            cls_d = CLS_OPERATOR;
          end else if (is_special(ch_q) && ch_q == nx_q) begin
            cls_d  = CLS_SPECIAL;
            pair_d = 1'b1;
          end else if (ch_q == CH_DOLLAR) begin
            cls_d = CLS_IDENT;
          end else if (ch_q == CH_PCT) begin
            cls_d = CLS_FIELD;
          end else if (ch_q == CH_QUOTE) begin
            cls_d = CLS_STRING;
          end else if (is_literal(ch_q)) begin
            cls_d = CLS_LITERAL;
          end else begin
            cls_d = CLS_DEFAULT;  // cr and lf stay default
          end
        end
        style_d = cls_d;
      end
    end

    // remember whether this byte ends a line
    if (ch_q == CH_CR) begin
      prev_d = LE_CR;
    end else if (ch_q == CH_LF) begin
      prev_d = LE_LF;
    end else begin
      prev_d = LE_NONE;
    end
  end

  // ---- control and state registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_style_q <= CLS_DEFAULT;
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      cls_q         <= CLS_DEFAULT;
      pair_q        <= 1'b0;
      prev_q        <= LE_NONE;
    end else begin
      if (cfg_we_i) begin
        start_style_q <= class_e'(cfg_wdata_i);
      end
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
        if (in_vld_q) begin
          cls_q  <= cls_d;
          pair_q <= pair_d;
          prev_q <= prev_d;
        end
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q    <= ch_i;
      nx_q    <= next_ch_i;
      first_q <= first_i;
      last_q  <= last_i;
    end
    if (advance && in_vld_q) begin
      style_q <= style_d;
      end_q   <= last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign style_o     = 3'(style_q);
  assign end_mark_o  = end_q;

  // ---- assertions ----
  // a pending pair is only ever a comment or a doubled special
  `ASSERT_CLK(a_pair_class, clk_i, rst_ni,
              !pair_q || (cls_q == CLS_COMMENT) || (cls_q == CLS_SPECIAL))
  // input side stalls only when both stages hold an item
  `ASSERT_CLK(a_stall_full, clk_i, rst_ni,
              in_ready_o || (in_vld_q && out_vld_q && !out_ready_i))
  // an item leaving the input register lands in the result register
  `ASSERT_NEXT(a_move_out, clk_i, rst_ni, advance && in_vld_q, out_vld_q)

endmodule

// File: tb/tb.sv
// ------------------------------------------------------------------------
// tb
// self-checking bench for the format-script byte classifier: a directed
// table of byte sequences, then random segments under every start style,
// each result checked against a cycle-free class predictor
// ------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fscc_pkg::*;

  // cycles with no item moving on either side before the run is abandoned
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS_PER_PHASE = 205;

  // one expected result item
  typedef struct packed {
    class_e style;
    logic   end_mark;
  } class_result_t;

  // one row of the directed table; known rows carry a typed-in class
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] nx;
    logic       first;
    logic       last;
    logic       known;
    class_e     style;
  } byte_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] ch_i = 8'h00;
  logic [7:0] next_ch_i = 8'h00;
  logic       first_i = 1'b0;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] style_o;
  logic       end_mark_o;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_wdata_i = 3'd0;

  // predictor state, mirrors the block after reset
  class_e     start_cls = CLS_DEFAULT;
  class_e     cur_cls = CLS_DEFAULT;
  logic       pair_pending = 1'b0;
  line_end_e  line_end = LE_NONE;

  class_result_t pending_classes [$];
  int unsigned   errors = 0;
  int unsigned   quiet_cycles = 0;
  logic          idle_on = 1'b1;
  int unsigned   stall_left = 0;

  // directed bytes: extremes, a comment across CR LF, every operator,
  // doubled specials, identifier, field, quoted string, and a segment
  // start that cuts a doubled special in half
  byte_row_t byte_rows [0:25] = '{
    '{8'h00,     8'hff,     1'b1, 1'b0, 1'b1, CLS_LITERAL},  // first byte after reset
    '{8'hff,     8'h00,     1'b0, 1'b1, 1'b0, CLS_DEFAULT},  // high byte is literal
    '{CH_SLASH,  CH_SLASH,  1'b1, 1'b0, 1'b0, CLS_DEFAULT},  // comment opener pair
    '{CH_SLASH,  CH_CR,     1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // second byte of the pair
    '{CH_CR,     CH_LF,     1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // still inside comment
    '{CH_LF,     "z",       1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // LF after CR is no line start
    '{"z",       CH_LPAR,   1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // line start ends comment
    '{CH_LPAR,   CH_RPAR,   1'b0, 1'b0, 1'b0, CLS_DEFAULT},
    '{CH_RPAR,   CH_COMMA,  1'b0, 1'b0, 1'b0, CLS_DEFAULT},
    '{CH_COMMA,  CH_LBRK,   1'b0, 1'b0, 1'b0, CLS_DEFAULT},
    '{CH_LBRK,   CH_RBRK,   1'b0, 1'b0, 1'b0, CLS_DEFAULT},
    '{CH_RBRK,   CH_DOLLAR, 1'b0, 1'b1, 1'b0, CLS_DEFAULT},
    '{CH_DOLLAR, CH_DOLLAR, 1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // doubled special
    '{CH_DOLLAR, CH_PCT,    1'b0, 1'b0, 1'b0, CLS_DEFAULT},
    '{CH_PCT,    "a",       1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // field opens
    '{"a",       CH_PCT,    1'b0, 1'b0, 1'b0, CLS_DEFAULT},
    '{CH_PCT,    CH_QUOTE,  1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // field closes on its byte
    '{CH_QUOTE,  "b",       1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // string opens
    '{"b",       CH_QUOTE,  1'b0, 1'b0, 1'b0, CLS_DEFAULT},
    '{CH_QUOTE,  CH_DOLLAR, 1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // string closes on its byte
    '{CH_DOLLAR, "k",       1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // identifier
    '{"k",       CH_UNDER,  1'b0, 1'b0, 1'b0, CLS_DEFAULT},
    '{CH_UNDER,  CH_CR,     1'b0, 1'b0, 1'b0, CLS_DEFAULT},
    '{CH_CR,     CH_PCT,    1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // CR ends identifier
    '{CH_PCT,    CH_PCT,    1'b0, 1'b0, 1'b0, CLS_DEFAULT},  // pair opens ...
    '{"q",       8'h00,     1'b1, 1'b1, 1'b1, CLS_LITERAL}   // ... and a new segment drops it
  };

  format_script_char_classifier DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .next_ch_i   (next_ch_i),
    .first_i     (first_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .style_o     (style_o),
    .end_mark_o  (end_mark_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // byte tests, ascii only: high bytes are never word bytes
  function automatic logic word_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == CH_UNDER;
  endfunction

  function automatic logic op_byte(input logic [7:0] c);
    return c inside {CH_LPAR, CH_RPAR, CH_COMMA, CH_LBRK, CH_RBRK};
  endfunction

  function automatic logic spec_byte(input logic [7:0] c);
    return c inside {CH_DOLLAR, CH_PCT, CH_QUOTE};
  endfunction

  function automatic logic lit_byte(input logic [7:0] c);
    return !op_byte(c) && !spec_byte(c) && c != CH_CR && c != CH_LF;
  endfunction

  // class of one byte; advances the predictor state
  function automatic class_e classify(input logic [7:0] c, input logic [7:0] nx,
                                      input logic seg_first);
    logic   at_line_start;
    logic   closed;
    class_e cls;
    closed = 1'b0;
    if (seg_first) begin
      cur_cls = start_cls;
      pair_pending = 1'b0;
      at_line_start = 1'b1;
    end else begin
      at_line_start = (line_end == LE_LF) || (line_end == LE_CR && c != CH_LF);
    end

    if (pair_pending) begin
      // second byte of a two-byte token takes the class unchanged
      pair_pending = 1'b0;
      cls = cur_cls;
    end else begin
      case (cur_cls)
        CLS_OPERATOR, CLS_SPECIAL: cur_cls = CLS_DEFAULT;
        CLS_IDENT: if (!word_byte(c)) cur_cls = CLS_DEFAULT;
        CLS_COMMENT: if (at_line_start) cur_cls = CLS_DEFAULT;
        CLS_STRING: closed = (c == CH_QUOTE);
        CLS_LITERAL: if (!lit_byte(c)) cur_cls = CLS_DEFAULT;
        CLS_FIELD: closed = (c == CH_PCT);
        default: ;
      endcase

      if (closed) begin
        // closing quote or percent keeps the class, nothing opens on it
        cls = cur_cls;
        cur_cls = CLS_DEFAULT;
      end else begin
        if (cur_cls == CLS_DEFAULT) begin
          if (c == CH_SLASH && nx == CH_SLASH) begin
            cur_cls = CLS_COMMENT;
            pair_pending = 1'b1;
          end else if (op_byte(c)) begin
            cur_cls = CLS_OPERATOR;
          end else if (spec_byte(c) && c == nx) begin
            cur_cls = CLS_SPECIAL;
            pair_pending = 1'b1;
          end else if (c == CH_DOLLAR) begin
            cur_cls = CLS_IDENT;
          end else if (c == CH_PCT) begin
            cur_cls = CLS_FIELD;
          end else if (c == CH_QUOTE) begin
            cur_cls = CLS_STRING;
          end else if (lit_byte(c)) begin
            cur_cls = CLS_LITERAL;
          end
        end
        cls = cur_cls;
      end
    end

    if (c == CH_CR) line_end = LE_CR;
    else if (c == CH_LF) line_end = LE_LF;
    else line_end = LE_NONE;
    return cls;
  endfunction

  // byte mix leaning on the characters that steer the classes
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    logic [7:0]  word_set [0:7];
    word_set = '{"a", "z", "A", "Z", "0", "9", CH_UNDER, "m"};
    r = $urandom_range(0, 99);
    if (r < 22) return word_set[$urandom_range(0, 7)];
    if (r < 36) begin
      case ($urandom_range(0, 2))
        0: return CH_DOLLAR;
        1: return CH_PCT;
        default: return CH_QUOTE;
      endcase
    end
    if (r < 48) begin
      case ($urandom_range(0, 4))
        0: return CH_LPAR;
        1: return CH_RPAR;
        2: return CH_COMMA;
        3: return CH_LBRK;
        default: return CH_RBRK;
      endcase
    end
    if (r < 56) return CH_SLASH;
    if (r < 66) return $urandom_range(0, 1) ? CH_CR : CH_LF;
    if (r < 72) return 8'h20;
    if (r < 82) return 8'(128 + $urandom_range(0, 127));
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one item; the expected class is queued as soon as it is offered
  task automatic send_byte(input logic [7:0] c, input logic [7:0] nx, input logic seg_first,
                           input logic seg_last, input logic known, input class_e typed);
    class_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    r.style = classify(c, nx, seg_first);
    if (known) r.style = typed;
    r.end_mark = seg_last;
    pending_classes.push_back(r);
    in_valid_i <= 1'b1;
    ch_i <= c;
    next_ch_i <= nx;
    first_i <= seg_first;
    last_i <= seg_last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // register write only once every result is out and the pipe has drained
  task automatic write_start_style(input class_e v);
    in_valid_i <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    start_cls = v;
  endtask

  // random segments: mostly well formed text with matching next byte and
  // first/last marks, some with a missing first mark, some raw noise items
  task automatic random_segments(input int unsigned n_items);
    logic [7:0]  seg [$];
    logic [7:0]  b;
    logic [7:0]  nx;
    logic        f;
    logic        l;
    logic        no_first;
    int unsigned sent;
    int unsigned seg_len;
    sent = 0;
    while (sent < n_items) begin
      seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
      seg.delete();
      while (seg.size() < seg_len) begin
        b = pick_byte();
        seg.push_back(b);
        // doubled bytes make "//" and doubled specials common
        if ($urandom_range(0, 5) == 0) seg.push_back(b);
      end
      no_first = ($urandom_range(0, 19) == 0);
      foreach (seg[i]) begin
        nx = (i < seg.size() - 1) ? seg[i + 1] : 8'h00;
        f = (i == 0) && !no_first;
        l = (i == seg.size() - 1);
        if ($urandom_range(0, 11) == 0) begin
          nx = 8'($urandom_range(0, 255));
          f = 1'($urandom_range(0, 1));
          l = 1'($urandom_range(0, 1));
        end
        send_byte(seg[i], nx, f, l, 1'b0, CLS_DEFAULT);
        sent++;
      end
    end
  endtask

  // result side: check each accepted item, then choose ready for the next edge
  always @(posedge clk_i) begin : result_check
    class_result_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_classes.size() == 0) begin
          $display("%0t: unexpected result style=%0d end_mark=%0b", $time, style_o,
                   end_mark_o);
          errors++;
        end else begin
          e = pending_classes.pop_front();
          if (style_o !== e.style) begin
            $display("%0t: style expected %0d actual %0d", $time, e.style, style_o);
            errors++;
          end
          if (end_mark_o !== e.end_mark) begin
            $display("%0t: end_mark expected %0b actual %0b", $time, e.end_mark, end_mark_o);
            errors++;
          end
        end
      end
      // output stalls come in bursts, counted down in stall_left
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles where no item moves on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    class_e phase_styles [0:7];
    // extremes first, then the rest, so every start class is used once
    phase_styles = '{CLS_FIELD, CLS_DEFAULT, CLS_COMMENT, CLS_STRING,
                     CLS_IDENT, CLS_LITERAL, CLS_OPERATOR, CLS_SPECIAL};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset start style
    foreach (byte_rows[i]) begin
      send_byte(byte_rows[i].ch, byte_rows[i].nx, byte_rows[i].first, byte_rows[i].last,
                byte_rows[i].known, byte_rows[i].style);
    end

    // one random phase per start style; the last one runs without idling
    foreach (phase_styles[p]) begin
      write_start_style(phase_styles[p]);
      idle_on = (p != 7);
      random_segments(RANDOM_ITEMS_PER_PHASE);
    end

    in_valid_i <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (errors == 0 && pending_classes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
